// ===== src/bfu_pkg.sv =====
`timescale 1ns / 1ps

package bfu_pkg;

  localparam int BPP_W       = 6;
  localparam int OFS_W       = 3;
  localparam int PIX_W       = 21;
  localparam int MODE_W      = 2;
  localparam int BYTE_W      = 8;
  localparam int PIXEL_W     = 32;
  localparam int USER_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 21;
  localparam int RUN_MAX     = 8;
  localparam int RUN_W       = 4;
  localparam int CMP_W       = 10;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [BPP_W-1:0] BPP_RESET   = 6'd8;
  localparam logic [OFS_W-1:0] OFS_RESET   = 3'd0;
  localparam logic [PIX_W-1:0] COUNT_RESET = 21'd1024;

  // Input item kinds carried in tuser
  localparam logic [MODE_W-1:0] MODE_DATA  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FILL  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BPP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd2;

  typedef struct packed {
    logic             is_fill;
    logic             fill_phase;
    logic             frame_end;
    logic [RUN_W-1:0] count;
  } job_ctrl_t;

endpackage

// ===== src/bfu_front.sv =====
`timescale 1ns / 1ps

module bfu_front #(
  parameter int MAX_FIELD_BITS = 32,
  parameter int MAX_PIXELS     = 1048576,
  parameter int ACC_W          = MAX_FIELD_BITS + 16,
  parameter int BITS_W         = $clog2(ACC_W + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bfu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfu_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bfu_pkg::MODE_W-1:0]       in_mode,
  input  logic [bfu_pkg::BYTE_W-1:0]       in_byte,
  input  logic                             q_full,
  output logic                             push,
  output bfu_pkg::job_ctrl_t               push_ctrl,
  output logic [ACC_W-1:0]                 push_acc,
  output logic [BITS_W-1:0]                push_bits,
  output logic [bfu_pkg::BPP_W-1:0]        field_width
);
  import bfu_pkg::*;

  logic [BPP_W-1:0]  bits_per_pixel;
  logic [OFS_W-1:0]  start_bit_offset;
  logic [PIX_W-1:0]  pixel_count;
  logic [ACC_W-1:0]  acc, acc_next;
  logic [BITS_W-1:0] acc_bits, acc_bits_next;
  logic [PIX_W-1:0]  pixels_emitted, pixels_emitted_next;
  logic              fill_phase, fill_phase_next;
  logic              data_ended, data_ended_next;
  logic              started, started_next;

  logic [BPP_W-1:0]  w;
  logic [PIX_W-1:0]  count_eff;
  logic [PIX_W-1:0]  remaining;
  logic              done;
  logic [RUN_W-1:0]  rem_cap;
  logic [OFS_W-1:0]  skip;
  logic [RUN_W-1:0]  take;
  logic [BYTE_W-1:0] byte_bits;
  logic [ACC_W-1:0]  acc_shift;
  logic [BITS_W-1:0] bits_new;
  logic [RUN_W-1:0]  nfit;
  logic [RUN_W-1:0]  n_data;
  logic [CMP_W-1:0]  used;
  logic [BITS_W-1:0] rest;
  logic [ACC_W-1:0]  keep_mask;
  logic [ACC_W-1:0]  flush_acc;
  logic              accept;

  assign w = (bits_per_pixel == '0) ? BPP_W'(1) :
             (bits_per_pixel > BPP_W'(MAX_FIELD_BITS)) ? BPP_W'(MAX_FIELD_BITS) :
             bits_per_pixel;
  assign field_width = w;

  assign count_eff = (pixel_count == '0) ? PIX_W'(1) :
                     (32'(pixel_count) > 32'(MAX_PIXELS)) ? PIX_W'(MAX_PIXELS) :
                     pixel_count;
  assign done      = pixels_emitted >= count_eff;
  assign remaining = count_eff - pixels_emitted;
  assign rem_cap   = (remaining < PIX_W'(RUN_MAX)) ? RUN_W'(remaining) : RUN_W'(RUN_MAX);

  // Offset applies to the first byte of the frame only
  assign skip      = started ? '0 : start_bit_offset;
  assign take      = RUN_W'(BYTE_W) - RUN_W'(skip);
  assign byte_bits = in_byte & (8'hFF >> skip);
  assign acc_shift = (acc << take) | ACC_W'(byte_bits);
  assign bits_new  = acc_bits + BITS_W'(take);

  // Count whole fields held: fields are at most eight per byte
  always_comb begin
    nfit = '0;
    for (int k = 1; k <= RUN_MAX; k++) begin
      if (CMP_W'(k) * CMP_W'(w) <= CMP_W'(bits_new)) nfit = nfit + RUN_W'(1);
    end
  end

  assign n_data    = (rem_cap < nfit) ? rem_cap : nfit;
  assign used      = CMP_W'(n_data) * CMP_W'(w);
  assign rest      = bits_new - BITS_W'(used);
  assign keep_mask = ~({ACC_W{1'b1}} << rest);
  // Partial field padded with zeros at its low end
  assign flush_acc = acc << (BITS_W'(w) - acc_bits);

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    acc_next            = acc;
    acc_bits_next       = acc_bits;
    pixels_emitted_next = pixels_emitted;
    fill_phase_next     = fill_phase;
    data_ended_next     = data_ended;
    started_next        = started;
    push                = 1'b0;
    push_ctrl           = '0;
    push_acc            = acc_shift;
    push_bits           = bits_new;
    if (accept) begin
      unique case (in_mode)
        MODE_DATA: begin
          if (!data_ended && !done) begin
            started_next        = 1'b1;
            acc_next            = acc_shift & keep_mask;
            acc_bits_next       = rest;
            pixels_emitted_next = pixels_emitted + PIX_W'(n_data);
            push                = n_data != '0;
            push_ctrl.count     = n_data;
          end
        end
        MODE_FLUSH: begin
          if (!data_ended) begin
            data_ended_next = 1'b1;
            acc_next        = '0;
            acc_bits_next   = '0;
            if (!done && acc_bits != '0 && acc_bits < BITS_W'(w)) begin
              push                = 1'b1;
              push_acc            = flush_acc;
              push_bits           = BITS_W'(w);
              push_ctrl.count     = RUN_W'(1);
              pixels_emitted_next = pixels_emitted + PIX_W'(1);
            end
          end
        end
        MODE_FILL: begin
          if (data_ended && !done) begin
            push                 = 1'b1;
            push_acc             = '0;
            push_bits            = '0;
            push_ctrl.is_fill    = 1'b1;
            push_ctrl.fill_phase = fill_phase;
            push_ctrl.count      = rem_cap;
            fill_phase_next      = fill_phase ^ rem_cap[0];
            pixels_emitted_next  = pixels_emitted + PIX_W'(rem_cap);
          end
        end
        default: begin
        end
      endcase
    end
    // drop any partial field held when the width is written
    if (cfg_we && cfg_index == REG_BPP) begin
      acc_next      = '0;
      acc_bits_next = '0;
    end
    push_ctrl.frame_end = pixels_emitted_next == count_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_pixel   <= BPP_RESET;
      start_bit_offset <= OFS_RESET;
      pixel_count      <= COUNT_RESET;
      acc              <= '0;
      acc_bits         <= '0;
      pixels_emitted   <= '0;
      fill_phase       <= 1'b0;
      data_ended       <= 1'b0;
      started          <= 1'b0;
    end else begin
      acc            <= acc_next;
      acc_bits       <= acc_bits_next;
      pixels_emitted <= pixels_emitted_next;
      fill_phase     <= fill_phase_next;
      data_ended     <= data_ended_next;
      started        <= started_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BPP:    bits_per_pixel   <= cfg_data[BPP_W-1:0];
          REG_OFFSET: start_bit_offset <= cfg_data[OFS_W-1:0];
          REG_COUNT:  pixel_count      <= cfg_data[PIX_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ===== src/bfu_queue.sv =====
`timescale 1ns / 1ps

module bfu_queue #(
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output logic [DATA_W-1:0] pop_data
);
  import bfu_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [DATA_W-1:0] entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W:0]    fill;

  assign full     = fill == (PTR_W+1)'(QUEUE_DEPTH);
  assign valid    = fill != '0;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_data;
        wr_ptr          <= wr_ptr + PTR_W'(1);
      end
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      case ({push, pop})
        2'b10:   fill <= fill + (PTR_W+1)'(1);
        2'b01:   fill <= fill - (PTR_W+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== src/bfu_back.sv =====
`timescale 1ns / 1ps

module bfu_back #(
  parameter int MAX_FIELD_BITS = 32,
  parameter int ACC_W          = MAX_FIELD_BITS + 16,
  parameter int BITS_W         = $clog2(ACC_W + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [bfu_pkg::BPP_W-1:0]      field_width,
  input  logic                           q_valid,
  output logic                           q_pop,
  input  bfu_pkg::job_ctrl_t             q_ctrl,
  input  logic [ACC_W-1:0]               q_acc,
  input  logic [BITS_W-1:0]              q_bits,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bfu_pkg::PIXEL_W-1:0]    m_tdata,
  output logic                           m_tlast,
  output logic [bfu_pkg::USER_W-1:0]     m_tuser
);
  import bfu_pkg::*;

  logic              job_valid;
  job_ctrl_t         job_ctrl;
  logic [ACC_W-1:0]  job_acc;
  logic [BITS_W-1:0] job_rest;

  logic                     out_free;
  logic                     emit;
  logic                     last;
  logic [BITS_W-1:0]        rest_after;
  logic [ACC_W-1:0]         field_mask;
  logic [ACC_W-1:0]         field;
  logic [ACC_W+PIXEL_W-1:0] field_wide;
  logic [PIXEL_W-1:0]       pixel;

  assign out_free   = !m_tvalid || m_tready;
  assign emit       = job_valid && out_free;
  assign last       = job_ctrl.count == RUN_W'(1);
  assign rest_after = job_rest - BITS_W'(field_width);
  assign field_mask = ~({ACC_W{1'b1}} << field_width);
  assign field      = (job_acc >> rest_after) & field_mask;
  assign field_wide = {{PIXEL_W{1'b0}}, field};
  assign pixel      = job_ctrl.is_fill ? PIXEL_W'(!job_ctrl.fill_phase)
                                       : field_wide[PIXEL_W-1:0];

  // Take the next job as the current one hands over its last pixel
  assign q_pop = q_valid && (!job_valid || (emit && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (q_pop) begin
        job_valid <= 1'b1;
        job_ctrl  <= q_ctrl;
        job_acc   <= q_acc;
        job_rest  <= q_bits;
      end else if (emit) begin
        if (last) begin
          job_valid <= 1'b0;
        end else begin
          job_ctrl.count      <= job_ctrl.count - RUN_W'(1);
          job_ctrl.fill_phase <= !job_ctrl.fill_phase;
          job_rest            <= rest_after;
        end
      end
      if (emit) begin
        m_tvalid   <= 1'b1;
        m_tdata    <= pixel;
        m_tlast    <= last && job_ctrl.frame_end;
        m_tuser[0] <= job_ctrl.is_fill;
        m_tuser[1] <= last;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/bitstream_field_unpacker_top.sv =====
`timescale 1ns / 1ps

// Bit stream field unpacker.
// Input channel s_*: one item per byte of the stream (tuser = 0), an end of
// data marker (tuser = 1) or a fill request (tuser = 2). Bytes are cut MSB
// first into fields of bits_per_pixel bits; an end marker emits any partial
// field zero padded, and each fill request emits up to eight padding pixels
// alternating 1,0,1,0 until the frame holds pixel_count pixels.
// Output channel m_*: one pixel per item; tlast marks the final pixel of the
// frame, tuser[1] the final pixel caused by one input item.
// Configuration: write cfg_we with cfg_index 0 (width), 1 (first-byte bit
// offset) or 2 (pixel count) while the block is idle.
// Throughput: one pixel per cycle out while m_tready is high; an input item is
// taken every cycle while the four-entry job queue has room, so a steady stream
// is paced by the single output stage, which gives up to eight pixels per item.
// Path: with the back end idle, the first pixel of an item passes the queue
// entry, the job register and the output register before it shows on m_*.
// Reset restores width 8, offset 0, count 1024 and starts a new frame.
// When m_tready is low the output register holds; the queue then fills and
// s_tready drops until the back end moves again.
module bitstream_field_unpacker_top #(
  parameter int MAX_FIELD_BITS = 32,
  parameter int MAX_PIXELS     = 1048576
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bfu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bfu_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [bfu_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
  input  logic [bfu_pkg::MODE_W-1:0]     s_tuser,   // [1:0] mode
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bfu_pkg::PIXEL_W-1:0]    m_tdata,   // [31:0] pixel_value
  output logic                           m_tlast,   // frame_last
  output logic [bfu_pkg::USER_W-1:0]     m_tuser    // [0] is_fill, [1] run_last
);
  import bfu_pkg::*;

  localparam int ACC_W  = MAX_FIELD_BITS + 16;
  localparam int BITS_W = $clog2(ACC_W + 1);
  localparam int CTRL_W = $bits(job_ctrl_t);
  localparam int JOB_W  = CTRL_W + BITS_W + ACC_W;

  logic              push;
  job_ctrl_t         push_ctrl;
  logic [ACC_W-1:0]  push_acc;
  logic [BITS_W-1:0] push_bits;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  logic [JOB_W-1:0]  q_push_data;
  logic [JOB_W-1:0]  q_pop_data;
  job_ctrl_t         q_ctrl;
  logic [ACC_W-1:0]  q_acc;
  logic [BITS_W-1:0] q_bits;
  logic [BPP_W-1:0]  field_width;

  assign q_push_data = {push_ctrl, push_bits, push_acc};
  assign q_ctrl      = job_ctrl_t'(q_pop_data[JOB_W-1 -: CTRL_W]);
  assign q_bits      = q_pop_data[ACC_W +: BITS_W];
  assign q_acc       = q_pop_data[ACC_W-1:0];

  bfu_front #(
    .MAX_FIELD_BITS (MAX_FIELD_BITS),
    .MAX_PIXELS     (MAX_PIXELS),
    .ACC_W          (ACC_W),
    .BITS_W         (BITS_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_mode     (s_tuser),
    .in_byte     (s_tdata),
    .q_full      (q_full),
    .push        (push),
    .push_ctrl   (push_ctrl),
    .push_acc    (push_acc),
    .push_bits   (push_bits),
    .field_width (field_width)
  );

  bfu_queue #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_pop_data)
  );

  bfu_back #(
    .MAX_FIELD_BITS (MAX_FIELD_BITS),
    .ACC_W          (ACC_W),
    .BITS_W         (BITS_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .field_width (field_width),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_ctrl      (q_ctrl),
    .q_acc       (q_acc),
    .q_bits      (q_bits),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser)
  );

endmodule

// ===== sim/bitstream_field_unpacker_top_tb.sv =====
`timescale 1ns / 1ps

module bitstream_field_unpacker_top_tb;
  import bfu_pkg::*;

  localparam int FIELD_CAP     = 32;
  localparam int PIXEL_CAP     = 1048576;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 2000;
  localparam int MAX_REPORTS   = 100;

  // tuser code the block has no use for
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int unsigned COUNT_ALL_ONES = 32'h001F_FFFF;

  typedef struct packed {
    bit [PIXEL_W-1:0] value;
    bit               fill;
    bit               frame_last;
    bit               run_last;
  } pixel_t;

  class pixel_scoreboard #(int WIDTH_CAP = 32, int COUNT_CAP = 1048576);
    bit [BPP_W-1:0] bpp;
    bit [OFS_W-1:0] first_skip;
    bit [PIX_W-1:0] frame_len;
    bit [63:0]      acc;
    int unsigned    acc_bits;
    int unsigned    skip;
    int unsigned    emitted;
    bit             fill_phase;
    bit             ended;
    bit             begun;
    pixel_t         burst[$];
    pixel_t         expected_pixels[$];
    int unsigned    errors;

    function new();
      bpp        = BPP_RESET;
      first_skip = OFS_RESET;
      frame_len  = COUNT_RESET;
      acc        = '0;
      acc_bits   = 0;
      skip       = 0;
      emitted    = 0;
      fill_phase = 1'b0;
      ended      = 1'b0;
      begun      = 1'b0;
      errors     = 0;
    endfunction

    function int unsigned field_width();
      if (bpp == 0) return 1;
      if (bpp > WIDTH_CAP) return WIDTH_CAP;
      return 32'(bpp);
    endfunction

    function int unsigned frame_count();
      if (frame_len == 0) return 1;
      if (frame_len > COUNT_CAP) return COUNT_CAP;
      return 32'(frame_len);
    endfunction

    function bit frame_complete();
      return emitted >= frame_count();
    endfunction

    function bit [63:0] low_mask(int unsigned n);
      return (n >= 64) ? {64{1'b1}} : ((64'd1 << n) - 64'd1);
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction

    function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_BPP: begin
          // a width change drops any partial field
          bpp      = val[BPP_W-1:0];
          acc      = '0;
          acc_bits = 0;
        end
        REG_OFFSET: first_skip = val[OFS_W-1:0];
        REG_COUNT:  frame_len  = val[PIX_W-1:0];
        default: ;
      endcase
    endfunction

    function void add_pixel(bit [63:0] v, bit is_fill);
      pixel_t p;
      emitted      = emitted + 1;
      p.value      = v[PIXEL_W-1:0];
      p.fill       = is_fill;
      p.frame_last = (emitted == frame_count());
      p.run_last   = 1'b0;
      burst.push_back(p);
    endfunction

    function void note_item(bit [MODE_W-1:0] mode, bit [BYTE_W-1:0] data_in);
      int unsigned w;
      int unsigned take;
      int unsigned rest;
      bit [63:0]   v;
      pixel_t      tail;
      w = field_width();
      burst.delete();
      case (mode)
        MODE_DATA: begin
          if (!ended && !frame_complete()) begin
            if (!begun) begin
              begun = 1'b1;
              skip  = 32'(first_skip);
            end
            take     = 8 - skip;
            skip     = 0;
            acc      = (acc << take) | (64'(data_in) & low_mask(take));
            acc_bits = acc_bits + take;
            while (acc_bits >= w && burst.size() < RUN_MAX && !frame_complete()) begin
              rest = acc_bits - w;
              v    = (acc >> rest) & low_mask(w);
              add_pixel(v, 1'b0);
              acc_bits = rest;
              acc      = acc & low_mask(rest);
            end
          end
        end
        MODE_FLUSH: begin
          if (!ended) begin
            ended = 1'b1;
            // pad the partial field with zeros at its low end
            if (!frame_complete() && acc_bits > 0 && acc_bits < w) begin
              v = (acc << (w - acc_bits)) & low_mask(w);
              add_pixel(v, 1'b0);
            end
            acc      = '0;
            acc_bits = 0;
          end
        end
        MODE_FILL: begin
          if (ended) begin
            while (burst.size() < RUN_MAX && !frame_complete()) begin
              add_pixel(fill_phase ? 64'd0 : 64'd1, 1'b1);
              fill_phase = ~fill_phase;
            end
          end
        end
        default: ;
      endcase
      if (burst.size() > 0) begin
        tail          = burst.pop_back();
        tail.run_last = 1'b1;
        burst.push_back(tail);
      end
      foreach (burst[i]) expected_pixels.push_back(burst[i]);
    endfunction

    task report(string msg);
      if (errors < MAX_REPORTS) $display("%0t ERROR: %s", $time, msg);
      errors++;
    endtask

    task check(logic [PIXEL_W-1:0] data, logic fin, logic [USER_W-1:0] user);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        report($sformatf("pixel %h with nothing outstanding", data));
        return;
      end
      want = expected_pixels.pop_front();
      if (data !== want.value)
        report($sformatf("pixel_value got %h want %h", data, want.value));
      if (user[0] !== want.fill)
        report($sformatf("is_fill got %b want %b (pixel %h)", user[0], want.fill, want.value));
      if (fin !== want.frame_last)
        report($sformatf("frame_last got %b want %b (pixel %h)", fin, want.frame_last,
                         want.value));
      if (user[1] !== want.run_last)
        report($sformatf("run_last got %b want %b (pixel %h)", user[1], want.run_last,
                         want.value));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata = '0;   // [7:0] data_byte
  logic [MODE_W-1:0]     s_tuser = '0;   // [1:0] mode
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [PIXEL_W-1:0]    m_tdata;        // [31:0] pixel_value
  logic                  m_tlast;        // frame_last
  logic [USER_W-1:0]     m_tuser;        // [0] is_fill, [1] run_last

  bit gaps_on = 1'b1;
  int unsigned quiet_cycles = 0;

  pixel_scoreboard #(.WIDTH_CAP(FIELD_CAP), .COUNT_CAP(PIXEL_CAP)) sb;

  bitstream_field_unpacker_top #(
    .MAX_FIELD_BITS(FIELD_CAP),
    .MAX_PIXELS    (PIXEL_CAP)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= (gaps_on && $urandom_range(99) < 8) ? 1'b0 : 1'b1;
  end

  // note accepted items before checking pixels taken at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_item(s_tuser, s_tdata);
      if (m_tvalid && m_tready) sb.check(m_tdata, m_tlast, m_tuser);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // valid stays high after a handshake so back-to-back items need no gap
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] data_in);
    if (gaps_on && $urandom_range(99) < 3) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= data_in;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // drop valid, wait for every outstanding pixel, then let the block sit idle
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    sb.load_reg(idx, CFG_DATA_W'(val));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_noise();
    int unsigned r;
    r = $urandom_range(2);
    case (r)
      0:       send_item(MODE_DATA, BYTE_W'($urandom_range(255)));
      1:       send_item(MODE_FLUSH, BYTE_W'($urandom_range(255)));
      default: send_item(MODE_SPARE, BYTE_W'($urandom_range(255)));
    endcase
  endtask

  initial begin
    int unsigned r;
    int unsigned n;
    int unsigned w_sel;

    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // 1-bit fields, first byte skips seven bits
    write_reg(REG_OFFSET, 0);
    write_reg(REG_OFFSET, 7);
    write_reg(REG_BPP, 1);
    write_reg(REG_COUNT, COUNT_ALL_ONES);
    send_item(MODE_DATA, 8'hFF);
    send_item(MODE_DATA, 8'h00);
    send_item(MODE_DATA, 8'hA5);
    send_item(MODE_SPARE, 8'hFF);
    send_item(MODE_FILL, 8'h3C);
    settle();

    // zero width acts as one bit
    write_reg(REG_BPP, 0);
    send_item(MODE_DATA, 8'h5A);
    settle();

    // oversized width clamps to the widest field; last byte stays partial
    write_reg(REG_BPP, 63);
    send_item(MODE_DATA, 8'hFF);
    send_item(MODE_DATA, 8'h00);
    send_item(MODE_DATA, 8'hFF);
    send_item(MODE_DATA, 8'h00);
    send_item(MODE_DATA, 8'hFF);
    settle();

    write_reg(REG_BPP, 32);
    send_item(MODE_DATA, 8'h80);
    send_item(MODE_DATA, 8'h00);
    send_item(MODE_DATA, 8'h00);
    send_item(MODE_DATA, 8'h01);
    settle();

    write_reg(REG_BPP, 5);
    repeat (3) send_item(MODE_DATA, BYTE_W'($urandom_range(255)));
    settle();

    // zero count acts as one, so the frame is already complete
    write_reg(REG_COUNT, 0);
    send_item(MODE_DATA, 8'hFF);
    settle();

    // reach the end of the frame mid-byte, then one byte past it
    write_reg(REG_BPP, 3);
    write_reg(REG_COUNT, sb.emitted + 3);
    send_item(MODE_DATA, 8'hFF);
    send_item(MODE_DATA, 8'h00);
    send_item(MODE_DATA, 8'h77);
    settle();

    for (int ph = 0; ph < 7; ph++) begin
      gaps_on = (ph != 3);
      r = $urandom_range(99);
      if (r < 88)      w_sel = $urandom_range(1, FIELD_CAP);
      else if (r < 94) w_sel = 0;
      else             w_sel = $urandom_range(FIELD_CAP + 1, 63);
      write_reg(REG_BPP, w_sel);
      if ($urandom_range(3) == 0) write_reg(REG_OFFSET, $urandom_range(7));
      if ($urandom_range(9) < 3) write_reg(REG_COUNT, sb.emitted + $urandom_range(1, 30));
      else                       write_reg(REG_COUNT, $urandom_range(PIXEL_CAP, COUNT_ALL_ONES));
      n = $urandom_range(9, 15);
      repeat (n) begin
        r = $urandom_range(99);
        if (r < 90)      send_item(MODE_DATA, BYTE_W'($urandom_range(255)));
        else if (r < 95) send_item(MODE_SPARE, BYTE_W'($urandom_range(255)));
        else             send_item(MODE_FILL, BYTE_W'($urandom_range(255)));
      end
      settle();
    end
    gaps_on = 1'b1;

    // end of data: with a partial byte held or with nothing held
    write_reg(REG_COUNT, COUNT_ALL_ONES);
    write_reg(REG_BPP, $urandom_range(9, FIELD_CAP));
    if ($urandom_range(1)) send_item(MODE_DATA, BYTE_W'($urandom_range(255)));
    send_item(MODE_FLUSH, BYTE_W'($urandom_range(255)));
    send_item(MODE_DATA, BYTE_W'($urandom_range(255)));
    send_item(MODE_FLUSH, BYTE_W'($urandom_range(255)));
    send_item(MODE_SPARE, BYTE_W'($urandom_range(255)));
    settle();

    for (int fp = 0; fp < 5; fp++) begin
      if (fp == 2) write_reg(REG_COUNT, COUNT_ALL_ONES);
      else         write_reg(REG_COUNT, sb.emitted + $urandom_range(1, 40));
      n = $urandom_range(3, 7);
      repeat (n) begin
        if ($urandom_range(99) < 85) send_item(MODE_FILL, BYTE_W'($urandom_range(255)));
        else                         send_noise();
      end
      settle();
    end

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== bitstream_field_unpacker_top.f =====
src/bfu_pkg.sv
src/bfu_front.sv
src/bfu_queue.sv
src/bfu_back.sv
src/bitstream_field_unpacker_top.sv
sim/bitstream_field_unpacker_top_tb.sv
